>>> rtl/plru_pkg.sv
package plru_pkg;

  localparam int unsigned EntriesDefault = 16;
  localparam int unsigned RefBitsDefault = 16;
  localparam int unsigned TagW           = 64;
  localparam int unsigned CmdW           = 3;
  localparam int unsigned StatusW        = 3;
  localparam int unsigned SlotW          = 4;
  localparam int unsigned RefOutW        = 16;
  localparam int unsigned CountW         = 5;

  typedef enum logic [CmdW-1:0] {
    CMD_LOOKUP = 3'd0,
    CMD_ALLOC  = 3'd1,
    CMD_INSERT = 3'd2,
    CMD_REMOVE = 3'd3,
    CMD_DECREF = 3'd4,
    CMD_QUERY  = 3'd5,
    CMD_FLUSH  = 3'd6,
    CMD_COUNT  = 3'd7
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_NO_SPACE  = 3'd3,
    ST_REF_ERROR = 3'd4
  } status_e;

  // recency move request from the sequencer to the order list
  typedef struct packed {
    logic start;
    logic to_mru;
  } move_req_t;

endpackage

>>> rtl/plru_order.sv
// Recency order list. position 0 is least recent. A move walks one position
// per cycle: first a search for the slot, then one shift step per cycle.
module plru_order #(
  parameter int unsigned Entries = plru_pkg::EntriesDefault,
  localparam int unsigned IdxW = (Entries > 1) ? $clog2(Entries) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  plru_pkg::move_req_t req_i,
  input  logic [IdxW-1:0]     slot_i,
  input  logic [IdxW-1:0]     rd_pos_i,
  output logic [IdxW-1:0]     rd_slot_o,
  output logic                busy_o
);

  typedef enum logic [2:0] {
    O_IDLE  = 3'b001,
    O_FIND  = 3'b010,
    O_SHIFT = 3'b100
  } ostate_e;

  localparam logic [IdxW-1:0] LastPos = IdxW'(Entries - 1);

  logic [IdxW-1:0] order_q [Entries];
  ostate_e         state_q, state_d;
  logic [IdxW-1:0] pos_q, pos_d;
  logic [IdxW-1:0] slot_q, slot_d;
  logic            mru_q, mru_d;

  assign rd_slot_o = order_q[rd_pos_i];
  assign busy_o    = (state_q != O_IDLE);

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    slot_d  = slot_q;
    mru_d   = mru_q;
    unique case (state_q)
      O_IDLE: begin
        if (req_i.start) begin
          state_d = O_FIND;
          pos_d   = '0;
          slot_d  = slot_i;
          mru_d   = req_i.to_mru;
        end
      end
      O_FIND: begin
        if (order_q[pos_q] == slot_q) begin
          state_d = O_SHIFT;
        end else if (pos_q == LastPos) begin
          state_d = O_IDLE;
        end else begin
          pos_d = pos_q + 1'b1;
        end
      end
      O_SHIFT: begin
        if (mru_q) begin
          if (pos_q == LastPos) state_d = O_IDLE;
          else pos_d = pos_q + 1'b1;
        end else begin
          if (pos_q == '0) state_d = O_IDLE;
          else pos_d = pos_q - 1'b1;
        end
      end
      default: state_d = O_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= O_IDLE;
      for (int i = 0; i < Entries; i++) order_q[i] <= IdxW'(Entries - 1 - i);
    end else begin
      state_q <= state_d;
      if (state_q == O_SHIFT) begin
        if (mru_q) begin
          if (pos_q == LastPos) order_q[pos_q] <= slot_q;
          else order_q[pos_q] <= order_q[pos_q + 1'b1];
        end else begin
          if (pos_q == '0) order_q[pos_q] <= slot_q;
          else order_q[pos_q] <= order_q[pos_q - 1'b1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    slot_q <= slot_d;
    mru_q  <= mru_d;
  end

endmodule

>>> rtl/pinned_lru_tag_cache.sv
// Tag cache with reference pinning and LRU replacement.
// Slave channel s_axis_*: one transfer is one command (opcode + 64-bit tag).
// Master channel m_axis_*: one result transfer per command (status, slot,
// hit flag, reference count, used and pinned slot counts).
// Commands run one at a time through a sequencer that reuses one tag
// comparator over the slots, one slot per cycle, and a recency list that
// moves an entry one position per cycle.
// A command may run a tag search, an alloc scan of the recency list and a move
// to the most or least recent end, and always ends with the occupancy count;
// s_axis_tready is low while one is in flight.
// The result sits in an output register; while the receiver stalls
// (m_axis_tready low) the block holds it. The next command may still be
// taken, but it waits in its final state until the held result is taken.
// Reset: all slots invalid with zero tag and count, slot ENTRIES-1 least
// recent down to slot 0 most recent. No clearing pass is needed.
module pinned_lru_tag_cache #(
  parameter int unsigned ENTRIES  = plru_pkg::EntriesDefault,
  parameter int unsigned REF_BITS = plru_pkg::RefBitsDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // 2:0 command, 66:3 tag, 71:67 zero
  input  logic [71:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // 2:0 status, 6:3 slot, 7 was_hit, 23:8 ref_count, 28:24 used_count,
  // 33:29 pinned_count, 39:34 zero
  output logic [39:0]  m_axis_tdata
);

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(ENTRIES + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(ENTRIES - 1);
  localparam logic [REF_BITS-1:0] RefMax = '1;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_FIND   = 9'b000000010,
    S_DECIDE = 9'b000000100,
    S_ASCAN  = 9'b000001000,
    S_FLCHK  = 9'b000010000,
    S_FLCLR  = 9'b000100000,
    S_MOVE   = 9'b001000000,
    S_COUNT  = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_e;

  logic [plru_pkg::TagW-1:0] tag_q [ENTRIES];
  logic                      valid_q [ENTRIES];
  logic [REF_BITS-1:0]       refs_q [ENTRIES];

  state_e                    state_q, state_d;
  plru_pkg::cmd_e            cmd_q;
  logic [plru_pkg::TagW-1:0] key_q;
  logic [IdxW-1:0]           idx_q, idx_d;
  logic [IdxW-1:0]           hit_idx_q, hit_idx_d;
  logic                      found_q, found_d;
  logic                      have_slot_q, have_slot_d;
  logic                      was_hit_q, was_hit_d;
  plru_pkg::status_e         status_q, status_d;
  logic [CntW-1:0]           used_q, used_d, pin_q, pin_d;
  logic                      move_wait_q, move_wait_d;
  logic [39:0]               out_q;
  logic                      out_vld_q;

  plru_pkg::move_req_t       mreq;
  logic [IdxW-1:0]           mslot;
  logic [IdxW-1:0]           ord_slot;
  logic                      ord_busy;

  // write strobes to the slot arrays
  logic                      wr_touch, wr_alloc, wr_remove, wr_dec, wr_clr;

  plru_order #(.Entries(ENTRIES)) u_order (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mreq),
    .slot_i    (mslot),
    .rd_pos_i  (idx_q),
    .rd_slot_o (ord_slot),
    .busy_o    (ord_busy)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  logic [REF_BITS-1:0] hit_refs;
  assign hit_refs = refs_q[hit_idx_q];

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    hit_idx_d   = hit_idx_q;
    found_d     = found_q;
    have_slot_d = have_slot_q;
    was_hit_d   = was_hit_q;
    status_d    = status_q;
    used_d      = used_q;
    pin_d       = pin_q;
    move_wait_d = move_wait_q;
    mreq        = '0;
    mslot       = hit_idx_q;
    wr_touch = 1'b0; wr_alloc = 1'b0; wr_remove = 1'b0;
    wr_dec   = 1'b0; wr_clr   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          idx_d = '0; found_d = 1'b0; have_slot_d = 1'b0; was_hit_d = 1'b0;
          status_d = plru_pkg::ST_OK; move_wait_d = 1'b0;
          if (s_axis_tdata[66:3] == '0 &&
              s_axis_tdata[2:0] != plru_pkg::CMD_FLUSH &&
              s_axis_tdata[2:0] != plru_pkg::CMD_COUNT) begin
            status_d = plru_pkg::ST_INVALID;
            state_d  = S_COUNT;
            used_d = '0; pin_d = '0;
          end else if (s_axis_tdata[2:0] == plru_pkg::CMD_ALLOC) begin
            state_d = S_ASCAN;
          end else if (s_axis_tdata[2:0] == plru_pkg::CMD_FLUSH) begin
            state_d = S_FLCHK;
          end else if (s_axis_tdata[2:0] == plru_pkg::CMD_COUNT) begin
            state_d = S_COUNT; used_d = '0; pin_d = '0;
          end else begin
            state_d = S_FIND;
          end
        end
      end
      // one comparator, one slot per cycle, lowest match wins
      S_FIND: begin
        if (valid_q[idx_q] && tag_q[idx_q] == key_q) begin
          found_d = 1'b1; hit_idx_d = idx_q; state_d = S_DECIDE;
        end else if (idx_q == LastIdx) begin
          state_d = S_DECIDE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_DECIDE: begin
        idx_d = '0;
        if (!found_q) begin
          if (cmd_q == plru_pkg::CMD_INSERT) begin
            state_d = S_ASCAN;
          end else begin
            status_d = plru_pkg::ST_NOT_FOUND;
            state_d = S_COUNT; used_d = '0; pin_d = '0;
          end
        end else begin
          have_slot_d = 1'b1;
          state_d = S_COUNT; used_d = '0; pin_d = '0;
          unique case (cmd_q) inside
            plru_pkg::CMD_LOOKUP, plru_pkg::CMD_INSERT: begin
              was_hit_d = 1'b1;
              if (hit_refs == RefMax) begin
                status_d = plru_pkg::ST_REF_ERROR;
              end else begin
                wr_touch = 1'b1;
                mreq = '{start: 1'b1, to_mru: 1'b1};
                state_d = S_MOVE;
              end
            end
            plru_pkg::CMD_REMOVE: begin
              if (hit_refs != REF_BITS'(1)) begin
                status_d = plru_pkg::ST_REF_ERROR;
              end else begin
                wr_remove = 1'b1;
                mreq = '{start: 1'b1, to_mru: 1'b0};
                state_d = S_MOVE;
              end
            end
            plru_pkg::CMD_DECREF: begin
              if (hit_refs == '0) status_d = plru_pkg::ST_REF_ERROR;
              else wr_dec = 1'b1;
            end
            default: ;
          endcase
        end
      end
      // walk recency order from least recent for an unpinned slot
      S_ASCAN: begin
        if (!valid_q[ord_slot] || refs_q[ord_slot] == '0) begin
          hit_idx_d = ord_slot; have_slot_d = 1'b1;
          wr_alloc = 1'b1;
          mslot = ord_slot;
          mreq = '{start: 1'b1, to_mru: 1'b1};
          state_d = S_MOVE;
        end else if (idx_q == LastIdx) begin
          status_d = plru_pkg::ST_NO_SPACE;
          idx_d = '0; state_d = S_COUNT; used_d = '0; pin_d = '0;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_FLCHK: begin
        if (refs_q[idx_q] != '0) begin
          status_d = plru_pkg::ST_REF_ERROR;
          idx_d = '0; state_d = S_COUNT; used_d = '0; pin_d = '0;
        end else if (idx_q == LastIdx) begin
          idx_d = '0; state_d = S_FLCLR;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_FLCLR: begin
        wr_clr = 1'b1;
        if (idx_q == LastIdx) begin
          idx_d = '0; state_d = S_COUNT; used_d = '0; pin_d = '0;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_MOVE: begin
        // first cycle here the list has just seen the request
        move_wait_d = 1'b1;
        if (move_wait_q && !ord_busy) begin
          idx_d = '0; state_d = S_COUNT; used_d = '0; pin_d = '0;
          move_wait_d = 1'b0;
        end
      end
      S_COUNT: begin
        if (valid_q[idx_q]) begin
          used_d = used_q + 1'b1;
          if (refs_q[idx_q] != '0) pin_d = pin_q + 1'b1;
        end
        if (idx_q == LastIdx) state_d = S_OUT;
        else idx_d = idx_q + 1'b1;
      end
      S_OUT: begin
        if (!out_vld_q || m_axis_tready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  logic [plru_pkg::SlotW-1:0]   slot_f;
  logic [plru_pkg::RefOutW-1:0] ref_f;
  logic [IdxW+plru_pkg::SlotW-1:0]       slot_ext;
  logic [REF_BITS+plru_pkg::RefOutW-1:0] ref_ext;
  logic [CntW+plru_pkg::CountW-1:0]      used_ext, pin_ext;
  logic                                  out_load;
  assign slot_ext = {{plru_pkg::SlotW{1'b0}}, hit_idx_q};
  assign ref_ext  = {{plru_pkg::RefOutW{1'b0}}, hit_refs};
  assign used_ext = {{plru_pkg::CountW{1'b0}}, used_q};
  assign pin_ext  = {{plru_pkg::CountW{1'b0}}, pin_q};
  assign slot_f = have_slot_q ? slot_ext[plru_pkg::SlotW-1:0] : '0;
  assign ref_f  = have_slot_q ? ref_ext[plru_pkg::RefOutW-1:0] : '0;
  assign out_load = (state_q == S_OUT) && (!out_vld_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        valid_q[i] <= 1'b0;
        refs_q[i]  <= '0;
        tag_q[i]   <= '0;
      end
    end else begin
      state_q   <= state_d;
      out_vld_q <= (out_vld_q && !m_axis_tready) || out_load;
      if (wr_touch) refs_q[hit_idx_q] <= hit_refs + 1'b1;
      if (wr_dec)   refs_q[hit_idx_q] <= hit_refs - 1'b1;
      if (wr_remove) begin
        valid_q[hit_idx_q] <= 1'b0;
        refs_q[hit_idx_q]  <= '0;
        tag_q[hit_idx_q]   <= '0;
      end
      if (wr_alloc) begin
        valid_q[ord_slot] <= 1'b1;
        refs_q[ord_slot]  <= REF_BITS'(1);
        tag_q[ord_slot]   <= key_q;
      end
      if (wr_clr) begin
        valid_q[idx_q] <= 1'b0;
        tag_q[idx_q]   <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && s_axis_tvalid) begin
      cmd_q <= plru_pkg::cmd_e'(s_axis_tdata[2:0]);
      key_q <= s_axis_tdata[66:3];
    end
    idx_q       <= idx_d;
    hit_idx_q   <= hit_idx_d;
    found_q     <= found_d;
    have_slot_q <= have_slot_d;
    was_hit_q   <= was_hit_d;
    status_q    <= status_d;
    used_q      <= used_d;
    pin_q       <= pin_d;
    move_wait_q <= move_wait_d;
    if (out_load) begin
      out_q <= {6'd0, pin_ext[plru_pkg::CountW-1:0], used_ext[plru_pkg::CountW-1:0],
                ref_f, was_hit_q, slot_f, status_q};
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !s_axis_tready)
    else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("result changed under stall");
  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({wr_touch, wr_alloc, wr_remove, wr_dec, wr_clr}))
    else $error("two slot writes at once");
  a_move_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mreq.start |-> !ord_busy)
    else $error("recency move while busy");
`endif

endmodule

>>> tb/pinned_lru_tag_cache_test.sv
module pinned_lru_tag_cache_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumSlots = 16;
  localparam logic [15:0] RefSat   = 16'hFFFF;
  localparam int unsigned PhaseLen = 400;

  // one result transfer, split into its fields (last field in the low bits)
  typedef struct packed {
    logic [4:0]        pinned_count;
    logic [4:0]        used_count;
    logic [15:0]       ref_count;
    logic              was_hit;
    logic [3:0]        slot;
    plru_pkg::status_e status;
  } answer_t;

  typedef struct packed {
    plru_pkg::cmd_e cmd;
    logic [63:0]    tag;
  } command_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;   // 2:0 command, 66:3 tag, 71:67 zero
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // 2:0 status, 6:3 slot, 7 was_hit, 23:8 ref_count,
                                    // 28:24 used_count, 33:29 pinned_count, 39:34 zero

  pinned_lru_tag_cache dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  initial forever #5 clk_i = ~clk_i;

  // shadow of the cache contents
  logic [63:0] slot_tag   [NumSlots];
  logic        slot_valid [NumSlots];
  logic [15:0] slot_refs  [NumSlots];
  logic [3:0]  recency    [NumSlots];  // index 0 is least recent

  command_t  pending_cmds[$];
  answer_t   awaited_answers[$];
  logic [63:0] tag_pool[24];
  int unsigned sent_count = 0;
  int unsigned recv_count = 0;
  bit          failed = 1'b0;
  bit          all_queued = 1'b0;

  function automatic int find_tag(logic [63:0] t);
    for (int i = 0; i < NumSlots; i++)
      if (slot_valid[i] && slot_tag[i] == t) return i;
    return -1;
  endfunction

  function automatic int order_pos(int s);
    for (int p = 0; p < NumSlots; p++)
      if (recency[p] == s[3:0]) return p;
    return 0;
  endfunction

  function automatic void to_most_recent(int s);
    int p;
    p = order_pos(s);
    for (; p < NumSlots - 1; p++) recency[p] = recency[p + 1];
    recency[NumSlots - 1] = s[3:0];
  endfunction

  function automatic void to_least_recent(int s);
    int p;
    p = order_pos(s);
    for (; p > 0; p--) recency[p] = recency[p - 1];
    recency[0] = s[3:0];
  endfunction

  // victim is the least recent slot that is free or unreferenced
  function automatic int claim_slot(logic [63:0] t);
    int s;
    for (int p = 0; p < NumSlots; p++) begin
      s = recency[p];
      if (!slot_valid[s] || slot_refs[s] == 0) begin
        to_most_recent(s);
        slot_valid[s] = 1'b1;
        slot_refs[s]  = 16'd1;
        slot_tag[s]   = t;
        return s;
      end
    end
    return -1;
  endfunction

  function automatic answer_t cache_step(command_t c);
    answer_t a;
    int s;
    bit busy;
    a = '0;
    a.status = plru_pkg::ST_OK;
    s = -1;
    if (c.tag == '0 && c.cmd != plru_pkg::CMD_FLUSH && c.cmd != plru_pkg::CMD_COUNT) begin
      a.status = plru_pkg::ST_INVALID;
    end else begin
      case (c.cmd) inside
        plru_pkg::CMD_LOOKUP, plru_pkg::CMD_INSERT: begin
          s = find_tag(c.tag);
          if (s >= 0) begin
            a.was_hit = 1'b1;
            if (slot_refs[s] >= RefSat) a.status = plru_pkg::ST_REF_ERROR;
            else begin
              slot_refs[s]++;
              to_most_recent(s);
            end
          end else if (c.cmd == plru_pkg::CMD_LOOKUP) begin
            a.status = plru_pkg::ST_NOT_FOUND;
          end else begin
            s = claim_slot(c.tag);
            if (s < 0) a.status = plru_pkg::ST_NO_SPACE;
          end
        end
        plru_pkg::CMD_ALLOC: begin
          s = claim_slot(c.tag);
          if (s < 0) a.status = plru_pkg::ST_NO_SPACE;
        end
        plru_pkg::CMD_REMOVE: begin
          s = find_tag(c.tag);
          if (s < 0) a.status = plru_pkg::ST_NOT_FOUND;
          else if (slot_refs[s] != 16'd1) a.status = plru_pkg::ST_REF_ERROR;
          else begin
            slot_valid[s] = 1'b0;
            slot_refs[s]  = '0;
            slot_tag[s]   = '0;
            to_least_recent(s);
          end
        end
        plru_pkg::CMD_DECREF: begin
          s = find_tag(c.tag);
          if (s < 0) a.status = plru_pkg::ST_NOT_FOUND;
          else if (slot_refs[s] == 0) a.status = plru_pkg::ST_REF_ERROR;
          else slot_refs[s]--;
        end
        plru_pkg::CMD_QUERY: begin
          s = find_tag(c.tag);
          if (s < 0) a.status = plru_pkg::ST_NOT_FOUND;
        end
        plru_pkg::CMD_FLUSH: begin
          busy = 1'b0;
          for (int i = 0; i < NumSlots; i++) if (slot_refs[i] != 0) busy = 1'b1;
          if (busy) a.status = plru_pkg::ST_REF_ERROR;
          else
            for (int i = 0; i < NumSlots; i++) begin
              slot_valid[i] = 1'b0;
              slot_tag[i]   = '0;
            end
        end
        default: ;
      endcase
    end
    for (int i = 0; i < NumSlots; i++)
      if (slot_valid[i]) begin
        a.used_count++;
        if (slot_refs[i] != 0) a.pinned_count++;
      end
    if (s >= 0) begin
      a.slot      = s[3:0];
      a.ref_count = slot_refs[s];
    end
    return a;
  endfunction

  // idle odds per phase: none, sender, receiver, both
  function automatic int unsigned send_idle_pct(int unsigned n);
    case (n / PhaseLen)
      1: return 69;
      3: return 8;
      default: return 0;
    endcase
  endfunction

  function automatic int unsigned recv_stall_pct(int unsigned n);
    case (n / PhaseLen)
      2: return 69;
      3: return 8;
      default: return 0;
    endcase
  endfunction

  // driver: predicts at the transfer edge, then offers the next command
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        awaited_answers.push_back(cache_step(command_t'({s_axis_tdata[2:0],
                                                         s_axis_tdata[66:3]})));
        sent_count++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct(sent_count)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {5'b0, pending_cmds[0].tag, pending_cmds[0].cmd};
          void'(pending_cmds.pop_front());
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result transfer against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    answer_t want, got;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct(recv_count));
      if (m_axis_tvalid && m_axis_tready) begin
        recv_count++;
        got = answer_t'(m_axis_tdata[33:0]);
        if (awaited_answers.size() == 0) begin
          $error("result transfer with nothing expected: %h", m_axis_tdata);
          failed = 1'b1;
        end else begin
          want = awaited_answers.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d actual %0d", want.status, got.status);
            failed = 1'b1;
          end
          if (got.slot !== want.slot) begin
            $error("slot: expected %0d actual %0d", want.slot, got.slot);
            failed = 1'b1;
          end
          if (got.was_hit !== want.was_hit) begin
            $error("was_hit: expected %0d actual %0d", want.was_hit, got.was_hit);
            failed = 1'b1;
          end
          if (got.ref_count !== want.ref_count) begin
            $error("ref_count: expected %0d actual %0d", want.ref_count, got.ref_count);
            failed = 1'b1;
          end
          if (got.used_count !== want.used_count) begin
            $error("used_count: expected %0d actual %0d", want.used_count, got.used_count);
            failed = 1'b1;
          end
          if (got.pinned_count !== want.pinned_count) begin
            $error("pinned_count: expected %0d actual %0d",
                   want.pinned_count, got.pinned_count);
            failed = 1'b1;
          end
        end
      end
    end
  end

  function automatic void queue_cmd(plru_pkg::cmd_e c, logic [63:0] t);
    command_t x;
    x.cmd = c;
    x.tag = t;
    pending_cmds.push_back(x);
  endfunction

  function automatic plru_pkg::cmd_e pick_cmd();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 20) return plru_pkg::CMD_LOOKUP;
    if (r < 30) return plru_pkg::CMD_ALLOC;
    if (r < 50) return plru_pkg::CMD_INSERT;
    if (r < 65) return plru_pkg::CMD_REMOVE;
    if (r < 85) return plru_pkg::CMD_DECREF;
    if (r < 93) return plru_pkg::CMD_QUERY;
    if (r < 96) return plru_pkg::CMD_FLUSH;
    return plru_pkg::CMD_COUNT;
  endfunction

  initial begin
    logic [63:0] t;
    for (int i = 0; i < NumSlots; i++) begin
      slot_tag[i]   = '0;
      slot_valid[i] = 1'b0;
      slot_refs[i]  = '0;
      recency[i]    = 4'(NumSlots - 1 - i);
    end
    // few tags so hits and full tables are common; random 64-bit values
    for (int i = 0; i < 24; i++) tag_pool[i] = {$urandom, $urandom} | 64'd1;
    tag_pool[0] = '1;
    tag_pool[1] = 64'h8000_0000_0000_0000;
    tag_pool[2] = 64'd1;

    // directed: zero tag, misses, hit/alloc, pinning errors, flush cases
    queue_cmd(plru_pkg::CMD_COUNT,  '0);
    queue_cmd(plru_pkg::CMD_FLUSH,  '0);
    queue_cmd(plru_pkg::CMD_LOOKUP, '0);
    queue_cmd(plru_pkg::CMD_ALLOC,  '0);
    queue_cmd(plru_pkg::CMD_REMOVE, '0);
    queue_cmd(plru_pkg::CMD_DECREF, '0);
    queue_cmd(plru_pkg::CMD_QUERY,  '0);
    queue_cmd(plru_pkg::CMD_LOOKUP, tag_pool[0]);
    queue_cmd(plru_pkg::CMD_INSERT, tag_pool[0]);
    queue_cmd(plru_pkg::CMD_INSERT, tag_pool[0]);
    queue_cmd(plru_pkg::CMD_REMOVE, tag_pool[0]);
    queue_cmd(plru_pkg::CMD_FLUSH,  '1);
    queue_cmd(plru_pkg::CMD_DECREF, tag_pool[0]);
    queue_cmd(plru_pkg::CMD_DECREF, tag_pool[0]);
    queue_cmd(plru_pkg::CMD_DECREF, tag_pool[0]);
    queue_cmd(plru_pkg::CMD_QUERY,  tag_pool[0]);
    queue_cmd(plru_pkg::CMD_ALLOC,  tag_pool[1]);
    queue_cmd(plru_pkg::CMD_ALLOC,  tag_pool[1]);
    queue_cmd(plru_pkg::CMD_QUERY,  tag_pool[1]);
    queue_cmd(plru_pkg::CMD_REMOVE, tag_pool[1]);
    queue_cmd(plru_pkg::CMD_REMOVE, tag_pool[1]);
    queue_cmd(plru_pkg::CMD_REMOVE, tag_pool[2]);
    queue_cmd(plru_pkg::CMD_FLUSH,  tag_pool[2]);
    queue_cmd(plru_pkg::CMD_COUNT,  tag_pool[2]);

    // random: many allocs fill the table so no space shows up
    for (int n = 0; n < 1600; n++) begin
      if ($urandom_range(99) < 3) t = '0;
      else t = tag_pool[$urandom_range(n % 200 < 100 ? 23 : 11)];
      queue_cmd(pick_cmd(), t);
    end
    all_queued = 1'b1;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (all_queued && pending_cmds.size() == 0 && !s_axis_tvalid
          && awaited_answers.size() == 0);
    repeat (200) @(posedge clk_i);
    if (!failed && awaited_answers.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

endmodule

>>> files.f
rtl/plru_pkg.sv
rtl/plru_order.sv
rtl/pinned_lru_tag_cache.sv
tb/pinned_lru_tag_cache_test.sv
